@@ hw/rtl/cgsr_pkg.sv @@
package cgsr_pkg;

  // Board geometry and size limit
  localparam int BOARD_COLS = 80;
  localparam int BOARD_ROWS = 25;
  localparam int MAX_SIZE   = 63;

  localparam int CELL_COUNT = BOARD_COLS * BOARD_ROWS;
  localparam int COL_W      = $clog2(BOARD_COLS);
  localparam int ROW_W      = $clog2(BOARD_ROWS);
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // Request and response field widths
  localparam int CMD_W    = 2;
  localparam int KIND_W   = 2;
  localparam int POS_W    = 8;
  localparam int SZ_W     = 6;
  localparam int CHAR_W   = 8;
  localparam int RROW_W   = 5;
  localparam int RCOL_W   = 7;

  // Scan offsets are signed, one bit wider than the size
  localparam int OFF_W    = SZ_W + 1;
  localparam int D2_W     = 2 * OFF_W + 1;
  localparam int CRD_W    = POS_W + 1;

  localparam logic [CHAR_W-1:0] BLANK_CELL = 8'h20;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Shape codes
  localparam logic [KIND_W-1:0] SHAPE_TRI    = 2'd0;
  localparam logic [KIND_W-1:0] SHAPE_CIRCLE = 2'd1;
  localparam logic [KIND_W-1:0] SHAPE_SQUARE = 2'd2;
  localparam logic [KIND_W-1:0] SHAPE_LINE   = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic setup;
    logic scan_en;
    logic clr_en;
    logic rd_en;
    logic rsp_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;
    logic clr_last;
  } dp_stat_t;

endpackage

@@ hw/rtl/cgsr_if.sv @@
// Request channel: one command per transfer
interface cgsr_req_if import cgsr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [KIND_W-1:0] shape_kind;
  logic              draw_mode;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [SZ_W-1:0]   shape_size;
  logic [CHAR_W-1:0] colour_byte;
  logic [RROW_W-1:0] read_row;
  logic [RCOL_W-1:0] read_col;

  modport source (
    output valid, command, shape_kind, draw_mode, pos_x, pos_y,
           shape_size, colour_byte, read_row, read_col,
    input  ready
  );
  modport sink (
    input  valid, command, shape_kind, draw_mode, pos_x, pos_y,
           shape_size, colour_byte, read_row, read_col,
    output ready
  );
endinterface

// Response channel: one cell value per request
interface cgsr_rsp_if import cgsr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] cell_value;

  modport source (output valid, cell_value, input ready);
  modport sink (input valid, cell_value, output ready);
endinterface

@@ hw/rtl/cgsr_ctrl.sv @@
module cgsr_ctrl import cgsr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_command,
  input  logic [SZ_W-1:0]  in_size,
  output logic             out_valid,
  input  logic             out_ready,
  output dp_cmd_t          cmd,
  input  dp_stat_t         stat
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SETUP  = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_CLEAR  = 3'd5;
  localparam logic [2:0] ST_READ   = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic [2:0] state, state_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_INIT: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_command == CMD_DRAW) begin
            state_next = (in_size == '0) ? ST_FINISH : ST_SETUP;
          end else if (in_command == CMD_CLEAR) begin
            state_next = ST_CLEAR;
          end else if (in_command == CMD_READ) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_FINISH;
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) state_next = ST_FINISH;
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.rsp_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

  // Output valid holds until the receiver takes the value
  always_comb begin
    if (cmd.rsp_load) out_valid_next = 1'b1;
    else              out_valid_next = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ hw/rtl/cgsr_datapath.sv @@
module cgsr_datapath import cgsr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [KIND_W-1:0] in_kind,
  input  logic              in_mode,
  input  logic signed [POS_W-1:0] in_x,
  input  logic signed [POS_W-1:0] in_y,
  input  logic [SZ_W-1:0]   in_size,
  input  logic [CHAR_W-1:0] in_colour,
  input  logic [RROW_W-1:0] in_rrow,
  input  logic [RCOL_W-1:0] in_rcol,
  output logic [CHAR_W-1:0] cell_value
);

  // Captured request
  logic [KIND_W-1:0]       cap_kind;
  logic                    cap_mode;
  logic signed [POS_W-1:0] cap_x, cap_y;
  logic [SZ_W-1:0]         cap_s;
  logic [CHAR_W-1:0]       cap_colour;
  logic                    cap_rd_ok;
  logic [ADDR_W-1:0]       cap_rd_addr;

  logic [SZ_W-1:0]   s_sat;
  logic              rd_ok;
  logic [ADDR_W-1:0] rd_addr_in;

  // Scan state
  logic signed [OFF_W-1:0] u, v;
  logic signed [OFF_W-1:0] s_x, s_m1, u_lo, u_hi, v_lo, v_hi;
  logic [D2_W-1:0] outer, inner, sq_s;
  logic [OFF_W-1:0] mag_u, mag_v;
  logic [D2_W-1:0] d2;
  logic            hit, sq_edge, on_board;
  logic signed [CRD_W-1:0] col_s, row_s;

  // Write pipeline stage
  logic              pipe_we;
  logic [COL_W-1:0]  pipe_col;
  logic [ROW_W-1:0]  pipe_row;
  logic [CHAR_W-1:0] pipe_colour;
  logic [ADDR_W-1:0] wr_addr;

  // Clearing sweep and frame memory
  logic [ADDR_W-1:0] clr_addr;
  logic [CHAR_W-1:0] mem [CELL_COUNT];
  logic [CHAR_W-1:0] rd_data;

  // Request decode at accept
  always_comb begin
    if (int'(in_size) > MAX_SIZE) s_sat = SZ_W'(MAX_SIZE);
    else                          s_sat = in_size;
    rd_ok = (in_command == CMD_READ) && (int'(in_rrow) < BOARD_ROWS)
            && (int'(in_rcol) < BOARD_COLS);
    rd_addr_in = ADDR_W'(in_rrow) * ADDR_W'(BOARD_COLS) + ADDR_W'(in_rcol);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cap_kind    <= in_kind;
      cap_mode    <= in_mode;
      cap_x       <= in_x;
      cap_y       <= in_y;
      cap_s       <= s_sat;
      cap_colour  <= in_colour;
      cap_rd_ok   <= rd_ok;
      cap_rd_addr <= rd_ok ? rd_addr_in : '0;
    end
  end

  // Scan box per shape
  always_comb begin
    s_x  = signed'({1'b0, cap_s});
    s_m1 = s_x - OFF_W'(1);
    sq_s = D2_W'(cap_s) * D2_W'(cap_s);
    case (cap_kind)
      SHAPE_TRI: begin
        u_lo = -s_m1; u_hi = s_m1; v_lo = '0; v_hi = s_m1;
      end
      SHAPE_CIRCLE: begin
        u_lo = -s_x; u_hi = s_x; v_lo = -s_x; v_hi = s_x;
      end
      default: begin
        u_lo = '0; u_hi = s_m1; v_lo = '0; v_hi = s_m1;
      end
    endcase
  end

  // Per-cell coverage test
  always_comb begin
    mag_u   = u[OFF_W-1] ? unsigned'(-u) : unsigned'(u);
    mag_v   = v[OFF_W-1] ? unsigned'(-v) : unsigned'(v);
    d2      = D2_W'(mag_u) * D2_W'(mag_u) + D2_W'(mag_v) * D2_W'(mag_v);
    sq_edge = (u == '0) || (u == s_m1) || (v == '0) || (v == s_m1);
    case (cap_kind)
      SHAPE_TRI:
        hit = cap_mode ? (mag_u < mag_v) : ((mag_u == mag_v) || (v == s_m1));
      SHAPE_CIRCLE:
        hit = cap_mode ? (d2 <= outer) : ((d2 > inner) && (d2 <= outer));
      SHAPE_SQUARE:
        hit = cap_mode ? !sq_edge : sq_edge;
      default:
        hit = (u == v);
    endcase
    col_s = CRD_W'(cap_x) + CRD_W'(u);
    row_s = CRD_W'(cap_y) + CRD_W'(v);
    on_board = !col_s[CRD_W-1] && (col_s[CRD_W-2:0] < (CRD_W-1)'(BOARD_COLS))
               && !row_s[CRD_W-1] && (row_s[CRD_W-2:0] < (CRD_W-1)'(BOARD_ROWS));
  end

  assign stat.scan_last = (u == u_hi) && (v == v_hi);
  assign stat.clr_last  = (clr_addr == ADDR_W'(CELL_COUNT - 1));

  // Scan counters and circle thresholds
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      u     <= u_lo;
      v     <= v_lo;
      outer <= sq_s + D2_W'(cap_s);
      inner <= sq_s - D2_W'(cap_s);
    end else if (cmd.scan_en) begin
      if (u == u_hi) begin
        u <= u_lo;
        v <= v + OFF_W'(1);
      end else begin
        u <= u + OFF_W'(1);
      end
    end
  end

  // Register one covered cell per cycle
  always_ff @(posedge clk) begin
    if (rst) pipe_we <= 1'b0;
    else     pipe_we <= cmd.scan_en && hit && on_board;
  end

  always_ff @(posedge clk) begin
    pipe_col    <= col_s[COL_W-1:0];
    pipe_row    <= row_s[ROW_W-1:0];
    pipe_colour <= cap_colour;
  end

  assign wr_addr = ADDR_W'(pipe_row) * ADDR_W'(BOARD_COLS) + ADDR_W'(pipe_col);

  // Clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= stat.clr_last ? '0 : clr_addr + ADDR_W'(1);
    end
  end

  // Frame memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_en) mem[clr_addr] <= BLANK_CELL;
    else if (pipe_we) mem[wr_addr] <= pipe_colour;
    if (cmd.rd_en) rd_data <= mem[cap_rd_addr];
  end

  // Response value
  always_ff @(posedge clk) begin
    if (cmd.rsp_load) cell_value <= cap_rd_ok ? rd_data : '0;
  end

endmodule

@@ hw/rtl/char_grid_shape_rasterizer_unit.sv @@
// Character-cell shape rasterizer with an 80 by 25 frame buffer.
// Requests arrive on req (valid/ready); each request returns exactly one
// response on rsp carrying cell_value: the addressed cell for a read,
// zero for draw, clear and unknown commands.
// Draw scans the shape's bounding box one cell per cycle: 2s-1 by s cells
// for a triangle, 2s+1 squared for a circle, s squared for square and line.
// The frame memory has a single write port.
// Clear writes one cell per cycle over all CELL_COUNT cells.
// Read goes through the registered memory read.
// One request is worked on at a time; req.ready is high only while idle.
// A finished response sits in an output register until rsp.ready; the
// next request is accepted while it waits, and its own response waits
// for that register to free up.
// Reset (rst, synchronous) starts a clearing pass that fills the buffer
// with spaces; req.ready stays low until it ends.
module char_grid_shape_rasterizer_unit import cgsr_pkg::*; (
  input logic        clk,
  input logic        rst,
  cgsr_req_if.sink   req,
  cgsr_rsp_if.source rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cgsr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .in_command (req.command),
    .in_size    (req.shape_size),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .cmd        (cmd),
    .stat       (stat)
  );

  cgsr_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_command (req.command),
    .in_kind    (req.shape_kind),
    .in_mode    (req.draw_mode),
    .in_x       (req.pos_x),
    .in_y       (req.pos_y),
    .in_size    (req.shape_size),
    .in_colour  (req.colour_byte),
    .in_rrow    (req.read_row),
    .in_rcol    (req.read_col),
    .cell_value (rsp.cell_value)
  );

endmodule
